// File: rtl/core/rpb_pkg.sv
// rpb_pkg: shared types and constants of the RGBA pixel blend unit.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package rpb_pkg;

    // blend mode codes
    typedef logic [2:0] t_mode;

    localparam t_mode MODE_COPY   = 3'd0;
    localparam t_mode MODE_KEEP_A = 3'd1;
    localparam t_mode MODE_FAST_A = 3'd2;
    localparam t_mode MODE_ADD    = 3'd3;
    localparam t_mode MODE_MULADD = 3'd4;
    localparam t_mode MODE_ALPHA  = 3'd5;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_COLOR = 1'b1;

    localparam t_mode       BLEND_MODE_RST  = MODE_COPY;
    localparam logic [31:0] BLEND_COLOR_RST = 32'hFFFF_FFFF;

    localparam logic [7:0] BYTE_MAX   = 8'hFF;
    localparam logic [7:0] MULADD_SAT = 8'hFE;
    localparam logic [4:0] FAST_FULL  = 5'd16;

    // word after the first stage: operands plus the shared alpha products
    typedef struct packed {
        t_mode       mode;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  a;     // sa * ca >> 8
        logic [23:0] tint;  // blend color R, G, B
        logic [23:0] addc;  // blend color premultiplied by its alpha
        logic [2:0]  mul;   // muladd factor, ca >> 5
    } t_s1;

    // word after the third stage: byte-wise results and bypass operands
    typedef struct packed {
        t_mode       mode;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] fa_pix;  // fast alpha mix
        logic        fa_we;   // fast alpha weight is not zero
        logic [31:0] ma_pix;  // fast muladd
        logic [7:0]  al_top;  // saturated alpha of the full blend
    } t_s3;

endpackage

`default_nettype wire

// File: rtl/core/rpb_front.sv
// rpb_front: first pipeline stage, blend alpha and premultiplied add color.
// Depends on rpb_pkg.
`default_nettype none

module rpb_front
    import rpb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mode       i_mode,
    input  wire logic [31:0] i_color,
    input  wire logic [31:0] i_src,
    input  wire logic [31:0] i_dst,
    output t_s1              o_s1
);

    t_s1         r_s1;
    t_s1         n_s1;
    logic [15:0] w_pa;
    logic [15:0] w_pc [3];
    logic [7:0]  w_ca;

    always_comb begin
        w_ca = i_color[31:24];
        w_pa = 16'(i_src[31:24]) * 16'(w_ca);
        for (int k = 0; k < 3; k++) begin
            w_pc[k] = 16'(i_color[8*k +: 8]) * 16'(w_ca);
        end

        n_s1.mode = i_mode;
        n_s1.src  = i_src;
        n_s1.dst  = i_dst;
        n_s1.a    = w_pa[15:8];
        n_s1.tint = i_color[23:0];
        n_s1.mul  = w_ca[7:5];
        // an opaque color is used as is
        for (int k = 0; k < 3; k++) begin
            n_s1.addc[8*k +: 8] = (w_ca != BYTE_MAX) ? w_pc[k][15:8] : i_color[8*k +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// File: rtl/core/rpb_lane.sv
// rpb_lane: one color channel, stages two and three of the full alpha blend
// and the additive blend. Depends on rpb_pkg.
`default_nettype none

module rpb_lane
    import rpb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic [7:0] i_src_ch,
    input  wire logic [7:0] i_dst_ch,
    input  wire logic [7:0] i_tint_ch,
    input  wire logic [7:0] i_addc_ch,
    input  wire logic [7:0] i_sa,
    input  wire logic [7:0] i_a,
    output logic [7:0]      o_alpha_ch,
    output logic [8:0]      o_add_sum
);

    // stage two: first products
    logic [15:0] r_p_sc;
    logic [15:0] r_p_ss;
    logic [16:0] r_p_dn;
    logic [7:0]  r_a;
    logic [7:0]  r_addc;
    logic [7:0]  r_dst;
    logic [8:0]  w_na;

    // stage three: second products
    logic [25:0] w_al;
    logic [23:0] w_q;
    logic [7:0]  r_alpha_ch;
    logic [8:0]  r_add_sum;

    assign w_na = 9'd256 - 9'(i_a);

    always_ff @(posedge i_clk) begin
        r_p_sc <= 16'(i_src_ch) * 16'(i_tint_ch);
        r_p_ss <= 16'(i_src_ch) * 16'(i_sa);
        r_p_dn <= 17'(i_dst_ch) * 17'(w_na);
        r_a    <= i_a;
        r_addc <= i_addc_ch;
        r_dst  <= i_dst_ch;
    end

    assign w_al = 26'(r_p_sc) * 26'(r_a) + {1'b0, r_p_dn, 8'd0};
    assign w_q  = 24'(r_p_ss) * 24'(r_addc);

    always_ff @(posedge i_clk) begin
        r_alpha_ch <= w_al[23:16];
        r_add_sum  <= 9'(w_q[23:16]) + 9'(r_dst);
    end

    assign o_alpha_ch = r_alpha_ch;
    assign o_add_sum  = r_add_sum;

endmodule

`default_nettype wire

// File: rtl/core/rpb_bytes.sv
// rpb_bytes: byte-parallel paths (fast alpha, fast muladd, alpha saturation)
// over stages two and three. Depends on rpb_pkg.
`default_nettype none

module rpb_bytes
    import rpb_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_s1  i_s1,
    output t_s3       o_s3
);

    t_s3        r_s2;
    t_s3        r_s3;
    t_s3        n_s2;
    logic [8:0] w_wsum;
    logic [4:0] w_w;
    logic [4:0] w_nw;
    logic [8:0] w_sat;
    logic [7:0] w_fa [4];
    logic [7:0] w_mv [4];

    always_comb begin
        w_wsum = 9'(i_s1.a) + 9'd8;
        w_w    = w_wsum[8:4];
        w_nw   = FAST_FULL - w_w;
        w_sat  = 9'(i_s1.dst[31:24]) + 9'(i_s1.a);

        for (int k = 0; k < 4; k++) begin
            w_fa[k] = 8'(i_s1.src[8*k+4 +: 4]) * 8'(w_w)
                    + 8'(i_s1.dst[8*k+4 +: 4]) * 8'(w_nw);
            w_mv[k] = 8'(i_s1.src[8*k+4 +: 4]) * 8'(i_s1.mul)
                    + 8'(i_s1.dst[8*k+1 +: 7]);
        end

        n_s2.mode = i_s1.mode;
        n_s2.src  = i_s1.src;
        n_s2.dst  = i_s1.dst;
        n_s2.fa_we = (w_w != 5'd0);
        for (int k = 0; k < 4; k++) begin
            n_s2.fa_pix[8*k +: 8] = (w_w == FAST_FULL) ? i_s1.src[8*k +: 8] : w_fa[k];
            // saturate on the top bit, then double
            n_s2.ma_pix[8*k +: 8] = w_mv[k][7] ? MULADD_SAT : {w_mv[k][6:0], 1'b0};
        end
        n_s2.al_top = w_sat[8] ? BYTE_MAX : w_sat[7:0];
    end

    // stage three only holds the word level with the lane products
    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
        r_s3 <= r_s2;
    end

    assign o_s3 = r_s3;

endmodule

`default_nettype wire

// File: rtl/core/rpb_sel.sv
// rpb_sel: final stage, mode select and output register.
// Depends on rpb_pkg.
`default_nettype none

module rpb_sel
    import rpb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_s3         i_s3,
    input  wire logic [23:0] i_al_rgb,
    input  wire logic [26:0] i_add_sum,
    output logic [31:0]      o_pixel,
    output logic             o_we
);

    logic [31:0] r_pixel;
    logic        r_we;
    logic [31:0] n_pixel;
    logic        n_we;
    logic [23:0] w_add_rgb;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_add_rgb[8*k +: 8] = i_add_sum[9*k+8] ? BYTE_MAX : i_add_sum[9*k +: 8];
        end

        n_pixel = i_s3.dst;
        n_we    = 1'b1;
        unique case (i_s3.mode)
            MODE_COPY:   n_pixel = i_s3.src;
            MODE_KEEP_A: n_pixel = {i_s3.dst[31:24], i_s3.src[23:0]};
            MODE_FAST_A: begin
                n_pixel = i_s3.fa_we ? i_s3.fa_pix : i_s3.dst;
                n_we    = i_s3.fa_we;
            end
            MODE_ADD:    n_pixel = {8'd0, w_add_rgb};
            MODE_MULADD: n_pixel = i_s3.ma_pix;
            MODE_ALPHA:  n_pixel = {i_s3.al_top, i_al_rgb};
            default: begin
                n_pixel = i_s3.dst;
                n_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
        r_we    <= n_we;
    end

    assign o_pixel = r_pixel;
    assign o_we    = r_we;

endmodule

`default_nettype wire

// File: rtl/core/rgba_pixel_blend_unit.sv
// rgba_pixel_blend_unit: four-stage RGBA8888 blender, one pixel word per clock.
// Timing: a word accepted at a rising edge moves through the stage registers of
// rpb_front, rpb_lane and rpb_bytes, and rpb_sel in that order and shows on the outputs
// with o_valid; throughput is one word a cycle outside reset, with no stall ever.
// The depth is set by two chained 8-bit products per channel (s*c*a, s*sa*col).
// Reset (synchronous, active low) drops all words in flight, sets the mode to copy
// and the color to all ones; busy is high only during reset. Results cannot stall.
// Depends on rpb_pkg, rpb_front, rpb_lane, rpb_bytes, rpb_sel.
`default_nettype none

module rgba_pixel_blend_unit
    import rpb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command side
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [31:0]          i_src_pixel,
    input  wire logic [31:0]          i_dst_pixel,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    // result side
    output logic                      o_valid,
    output logic [31:0]               o_out_pixel,
    output logic                      o_write_enable
);

    t_mode       r_blend_mode;
    logic [31:0] r_blend_color;
    logic [3:0]  r_vld;      // one valid bit per stage, output stage on top
    logic        w_accept;
    t_s1         w_s1;
    t_s3         w_s3;
    logic [23:0] w_al_rgb;
    logic [26:0] w_add_sum;

    // The pipeline never backs up, so only reset holds off new words.
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // Configuration: write straight into the registers, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode  <= BLEND_MODE_RST;
            r_blend_color <= BLEND_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BLEND_MODE:  r_blend_mode  <= i_cfg_data[2:0];
                REG_BLEND_COLOR: r_blend_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits advance one stage a clock alongside the payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], w_accept};
        end
    end

    // Stage one: blend alpha, premultiplied add color, operand capture.
    rpb_front u_front (
        .i_clk   (i_clk),
        .i_mode  (r_blend_mode),
        .i_color (r_blend_color),
        .i_src   (i_src_pixel),
        .i_dst   (i_dst_pixel),
        .o_s1    (w_s1)
    );

    // Stages two and three: per-channel multiply chains.
    for (genvar k = 0; k < 3; k++) begin : g_lane
        rpb_lane u_lane (
            .i_clk      (i_clk),
            .i_src_ch   (w_s1.src[8*k +: 8]),
            .i_dst_ch   (w_s1.dst[8*k +: 8]),
            .i_tint_ch  (w_s1.tint[8*k +: 8]),
            .i_addc_ch  (w_s1.addc[8*k +: 8]),
            .i_sa       (w_s1.src[31:24]),
            .i_a        (w_s1.a),
            .o_alpha_ch (w_al_rgb[8*k +: 8]),
            .o_add_sum  (w_add_sum[9*k +: 9])
        );
    end

    // Stages two and three: byte-wise fast paths and alpha saturation.
    rpb_bytes u_bytes (
        .i_clk (i_clk),
        .i_s1  (w_s1),
        .o_s3  (w_s3)
    );

    // Stage four: pick the result of the word's mode and register it.
    rpb_sel u_sel (
        .i_clk     (i_clk),
        .i_s3      (w_s3),
        .i_al_rgb  (w_al_rgb),
        .i_add_sum (w_add_sum),
        .o_pixel   (o_out_pixel),
        .o_we      (o_write_enable)
    );

    assign o_valid = r_vld[3];

    // Each result strobe matches an accepted word, unless reset came between.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == ($past(w_accept, 4) && $past(i_rst_n, 3) && $past(i_rst_n, 2)
                    && $past(i_rst_n, 1)))
        else $error("result strobe does not match accepted word");

    // Only fast alpha or a meaningless mode may suppress the write.
    a_we_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |->
        ($past(w_s3.mode) == MODE_FAST_A || $past(w_s3.mode) > MODE_ALPHA))
        else $error("write suppressed in a writing mode");

    // A suppressed write hands back the destination pixel unchanged.
    a_we_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_out_pixel == $past(w_s3.dst)))
        else $error("suppressed write changed the pixel");

    // The additive blend always writes alpha as zero.
    a_add_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(w_s3.mode) == MODE_ADD) |-> (o_out_pixel[31:24] == 8'd0))
        else $error("additive blend wrote nonzero alpha");

endmodule

`default_nettype wire

// File: verif/rgba_pixel_blend_unit_tb.sv
// rgba_pixel_blend_unit_tb: self-checking testbench of the RGBA8888 pixel blender.
// Drives pixel words and blend settings, predicts each result and compares it.
// Depends on rpb_pkg and rgba_pixel_blend_unit; needs nothing else.
`timescale 1ns / 100ps

module rgba_pixel_blend_unit_tb;
    import rpb_pkg::*;

    // mode codes that carry no operation; the block must write nothing for them
    localparam t_mode MODE_NONE_LO = 3'd6;
    localparam t_mode MODE_NONE_HI = 3'd7;

    localparam logic [31:0] NIB_HI   = 32'hF0F0_F0F0;
    localparam int          N_WORDS  = 2000;   // random words to send
    localparam int          N_QUIET  = 300;    // tail of the run with no idling
    localparam int          TAIL_CYC = 10;     // settle time after the last result
    localparam int          LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [31:0] pix;
        logic        we;
    } blend_out_t;

    // Predict each accepted word and hold the expected results in order.
    class blend_scoreboard;
        t_mode       mode;
        logic [31:0] color;
        blend_out_t  pending_pixels[$];
        int          errors;
        int          checked;

        function new();
            mode    = BLEND_MODE_RST;
            color   = BLEND_COLOR_RST;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_BLEND_MODE)
                mode = t_mode'(data[2:0]);
            else if (idx == REG_BLEND_COLOR)
                color = data;
        endfunction

        function blend_out_t blend_pixel(logic [31:0] s, logic [31:0] d);
            blend_out_t  r;
            logic [7:0]  sa, ca, da, a, ck, nb;
            logic [15:0] prod, cp;
            logic [8:0]  wsum, sum, asum;
            logic [4:0]  w;
            logic [2:0]  m;
            logic [23:0] p3;
            logic [31:0] na, mix;
            sa    = s[31:24];
            ca    = color[31:24];
            da    = d[31:24];
            prod  = sa * ca;
            a     = prod[15:8];
            r.pix = d;
            r.we  = 1'b1;
            case (mode)
                MODE_COPY: r.pix = s;
                MODE_KEEP_A: r.pix = {d[31:24], s[23:0]};
                MODE_FAST_A: begin
                    // weight rounds the product to 0..16
                    wsum = {1'b0, a} + 9'd8;
                    w    = wsum[8:4];
                    if (w == 5'd0)
                        r.we = 1'b0;
                    else if (w < FAST_FULL)
                        r.pix = ((s & NIB_HI) >> 4) * 32'(w)
                              + ((d & NIB_HI) >> 4) * (32'(FAST_FULL) - 32'(w));
                    else
                        r.pix = s;
                end
                MODE_ADD: begin
                    for (int k = 0; k < 3; k++) begin
                        ck = color[8*k +: 8];
                        cp = ck * ca;
                        if (ca != BYTE_MAX)
                            ck = cp[15:8];
                        p3  = s[8*k +: 8] * sa * ck;
                        sum = p3[23:16] + d[8*k +: 8];
                        r.pix[8*k +: 8] = sum[8] ? BYTE_MAX : sum[7:0];
                    end
                    r.pix[31:24] = 8'h00;
                end
                MODE_MULADD: begin
                    m = color[31:29];
                    for (int k = 0; k < 4; k++) begin
                        nb = s[8*k+4 +: 4] * m + d[8*k+1 +: 7];
                        r.pix[8*k +: 8] = nb[7] ? MULADD_SAT : {nb[6:0], 1'b0};
                    end
                end
                MODE_ALPHA: begin
                    na   = (32'd256 - 32'(a)) << 8;
                    asum = da + a;
                    for (int k = 0; k < 3; k++) begin
                        mix = s[8*k +: 8] * color[8*k +: 8] * a + d[8*k +: 8] * na;
                        r.pix[8*k +: 8] = mix[23:16];
                    end
                    r.pix[31:24] = asum[8] ? BYTE_MAX : asum[7:0];
                end
                default: r.we = 1'b0;
            endcase
            return r;
        endfunction

        function void note_input(logic [31:0] s, logic [31:0] d);
            pending_pixels.push_back(blend_pixel(s, d));
        endfunction

        function void check_result(logic [31:0] pix, logic we);
            blend_out_t exp_out;
            if (pending_pixels.size() == 0) begin
                $error("result with no word pending: out_pixel %h write_enable %b", pix, we);
                errors++;
                return;
            end
            exp_out = pending_pixels.pop_front();
            checked++;
            if (pix !== exp_out.pix) begin
                $error("out_pixel: expected %h, actual %h", exp_out.pix, pix);
                errors++;
            end
            if (we !== exp_out.we) begin
                $error("write_enable: expected %b, actual %b", exp_out.we, we);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [31:0]          i_src_pixel = '0;
    logic [31:0]          i_dst_pixel = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 o_valid;
    logic [31:0]          o_out_pixel;
    logic                 o_write_enable;

    blend_scoreboard sb = new();

    // settings as last driven onto the port, and run statistics
    t_mode       cur_mode = BLEND_MODE_RST;
    logic [31:0] cur_color = BLEND_COLOR_RST;
    bit          quiet = 1'b0;
    int          words_sent = 0;
    int          settings_used = 0;
    int          mode_hits[8];

    rgba_pixel_blend_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_src_pixel    (i_src_pixel),
        .i_dst_pixel    (i_dst_pixel),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_out_pixel    (o_out_pixel),
        .o_write_enable (o_write_enable)
    );

    always #4 i_clk = ~i_clk;

    // Monitor: sample pre-edge values at each rising edge. Register writes are applied
    // first, though the block gives a word taken at the same edge the old settings; writes only come with start low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                sb.note_input(i_src_pixel, i_dst_pixel);
            if (o_valid)
                sb.check_result(o_out_pixel, o_write_enable);
        end
    end

    // Hold one word on the command port until the block takes it. Keep start
    // high on return so back-to-back words need no toggle.
    task automatic send_word(logic [31:0] src, logic [31:0] dst);
        start       <= 1'b1;
        i_src_pixel <= src;
        i_dst_pixel <= dst;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        words_sent++;
        mode_hits[cur_mode]++;
    endtask

    // Drop start for a random burst now and then, unless in the quiet tail.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every predicted result has come back. The first
    // edge lets the monitor record the word accepted at the current edge.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Write both registers back to back; call only with the block drained.
    // Give the mode write junk upper bits, since only the low three count.
    task automatic write_config(t_mode mode, logic [31:0] color);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BLEND_MODE;
        i_cfg_data <= ($urandom() & ~32'h7) | 32'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= REG_BLEND_COLOR;
        i_cfg_data <= color;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_mode   = mode;
        cur_color  = color;
        settings_used++;
    endtask

    // Directed word: reprogram only when the settings change.
    task automatic directed(t_mode mode, logic [31:0] color, logic [31:0] src,
                            logic [31:0] dst);
        if (mode != cur_mode || color != cur_color) begin
            drain();
            write_config(mode, color);
        end
        send_word(src, dst);
        maybe_idle();
    endtask

    // Bias pixels toward saturated bytes and opaque or clear alpha.
    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return {8'hFF, 24'($urandom())};
            3:       return {8'h00, 24'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_color();
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return {8'hFF, 24'($urandom())};
            3:       return {8'h00, 24'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        phase = $urandom_range(0, 7);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: copy with an all-ones color
        directed(MODE_COPY,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        directed(MODE_COPY,    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        drain();
        write_config(MODE_COPY, 32'h0000_0000);
        directed(MODE_COPY,    32'h0000_0000, 32'hA5C3_0F96, 32'h5A3C_F069);
        directed(MODE_KEEP_A,  32'hFFFF_FFFF, 32'h1234_5678, 32'hAABB_CCDD);
        directed(MODE_KEEP_A,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        // fast alpha: full weight, zero weight, mid weight, smallest weight
        directed(MODE_FAST_A,  32'hFFFF_FFFF, 32'hFF80_4020, 32'h00FF_FFFF);
        directed(MODE_FAST_A,  32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h1122_3344);
        directed(MODE_FAST_A,  32'hFFFF_FFFF, 32'h80F0_A050, 32'h0F0F_0F0F);
        directed(MODE_FAST_A,  32'h10FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        // add: saturation, clear source, premultiplied color, clear color
        directed(MODE_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed(MODE_ADD,     32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
        directed(MODE_ADD,     32'h80C0_A060, 32'hFF80_8080, 32'h1020_3040);
        directed(MODE_ADD,     32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h0102_0304);
        // muladd: byte saturation, zero factor, mid values
        directed(MODE_MULADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed(MODE_MULADD,  32'h1FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        directed(MODE_MULADD,  32'hE000_0000, 32'h1020_3040, 32'h0246_8ACE);
        // full alpha: alpha saturation, zero alpha, tint, clear color
        directed(MODE_ALPHA,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0000);
        directed(MODE_ALPHA,   32'hFFFF_FFFF, 32'h0000_0000, 32'h80FF_FFFF);
        directed(MODE_ALPHA,   32'h80FF_8040, 32'hC010_2030, 32'h40A0_B0C0);
        directed(MODE_ALPHA,   32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF);
        // codes with no operation write nothing
        directed(MODE_NONE_LO, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0);
        directed(MODE_NONE_HI, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);

        // Random phases: walk the mode codes in turn, fresh color each phase.
        // Each phase boundary pauses the sender until all results are back.
        n = words_sent + N_WORDS;
        while (words_sent < n) begin
            quiet = (words_sent >= n - N_QUIET);
            drain();
            write_config(t_mode'(phase % 8), rand_color());
            phase++;
            repeat ($urandom_range(40, 200)) begin
                send_word(rand_pixel(), rand_pixel());
                maybe_idle();
            end
        end

        // Drain, then give the pipeline time to show any stray word.
        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d pixel words under %0d blend settings, %0d results checked.",
                 words_sent, settings_used, sb.checked);
        $display("Words per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #(LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
